>>> rtl/core/pshs_pkg.sv
// ----------------------------------------------------------------------------
// pshs_pkg: shared types and constants of the pointer hash set
// Request and response beats, work items, status codes and hash constants.
// ----------------------------------------------------------------------------
package pshs_pkg;

  localparam int unsigned CntW = 11;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [63:0] KEY_EMPTY = 64'd0;
  localparam logic [63:0] KEY_TOMB  = 64'd1;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  localparam logic [CntW-1:0] LOAD_LIMIT_RST = 11'd640;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5,
    ST_INVALID  = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] payload_in;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [63:0]     payload_out;
    logic [CntW-1:0] live_count;
  } rsp_t;

  typedef struct packed {
    logic        bad;
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] payload;
  } work_t;

endpackage

>>> rtl/core/pshs_front.sv
// ----------------------------------------------------------------------------
// pshs_front: request intake and home slot hash
// Flags reserved keys and unused actions, runs the 64-bit finalizer on one
// shared 32x32 multiplier and reduces it to a home slot.
// ----------------------------------------------------------------------------
module pshs_front import pshs_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024,
  localparam int unsigned IdxW = $clog2(TABLE_SLOTS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  req_t            in_data_i,
  input  logic            hold_i,
  output logic            push_o,
  input  logic            full_i,
  output work_t           work_o,
  output logic [IdxW-1:0] home_o
);

  localparam bit IsPow2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [63:0] NS = 64'(TABLE_SLOTS);
  // byte weights 2^(8i) mod slots for the fold
  localparam logic [15:0] FoldK1 = 16'((64'd1 << 8) % NS);
  localparam logic [15:0] FoldK2 = 16'((64'd1 << 16) % NS);
  localparam logic [15:0] FoldK3 = 16'((64'd1 << 24) % NS);
  localparam logic [15:0] FoldK4 = 16'((64'd1 << 32) % NS);
  localparam logic [15:0] FoldK5 = 16'((64'd1 << 40) % NS);
  localparam logic [15:0] FoldK6 = 16'((64'd1 << 48) % NS);
  localparam logic [15:0] FoldK7 = 16'((64'd1 << 56) % NS);
  // folded value stays below 2^27; reciprocal exact for that range
  localparam int unsigned RecS   = 27 + IdxW;
  localparam logic [63:0] RecipM = ((64'd1 << RecS) + NS - 64'd1) / NS;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_MIX, F_FIN, F_MOD, F_PUSH} fstate_e;

  fstate_e         state_q;
  logic [1:0]      phase_q;
  logic            round_q;
  logic [63:0]     x_q, acc_q, sh_q;
  logic [IdxW-1:0] home_q;
  logic [1:0]      bit_q;
  work_t           item_q;

  logic [63:0] cst, prod, acc_d, hval;
  logic [31:0] mul_a, mul_b;
  logic [31:0] fold, rem;
  logic [63:0] qp;
  logic accept;

  assign cst = round_q ? MIX_C2 : MIX_C1;

  always_comb begin
    case (phase_q)
      2'd0: begin
        mul_a = x_q[31:0];
        mul_b = cst[31:0];
      end
      2'd1: begin
        mul_a = x_q[31:0];
        mul_b = cst[63:32];
      end
      default: begin
        mul_a = x_q[63:32];
        mul_b = cst[31:0];
      end
    endcase
  end

  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign acc_d = (phase_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'd0};
  assign hval  = acc_q ^ (acc_q >> 31);
  assign fold  = 32'(sh_q[7:0]) +
                 32'(sh_q[15:8])  * 32'(FoldK1) + 32'(sh_q[23:16]) * 32'(FoldK2) +
                 32'(sh_q[31:24]) * 32'(FoldK3) + 32'(sh_q[39:32]) * 32'(FoldK4) +
                 32'(sh_q[47:40]) * 32'(FoldK5) + 32'(sh_q[55:48]) * 32'(FoldK6) +
                 32'(sh_q[63:56]) * 32'(FoldK7);
  assign qp    = 64'({5'd0, acc_q[26:0]}) * 64'(RecipM[31:0]);
  assign rem   = acc_q[31:0] - sh_q[31:0] * NS[31:0];

  assign accept     = (state_q == F_IDLE) && in_valid_i && !hold_i;
  assign in_stall_o = (state_q != F_IDLE) || hold_i;
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign work_o     = item_q;
  assign home_o     = home_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      phase_q <= 2'd0;
      round_q <= 1'b0;
      x_q     <= '0;
      acc_q   <= '0;
      sh_q    <= '0;
      home_q  <= '0;
      bit_q   <= '0;
      item_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            item_q.bad     <= (in_data_i.key == KEY_EMPTY) || (in_data_i.key == KEY_TOMB) ||
                              (in_data_i.action != ACT_INSERT && in_data_i.action != ACT_REMOVE
                               && in_data_i.action != ACT_LOOKUP);
            item_q.action  <= in_data_i.action;
            item_q.key     <= in_data_i.key;
            item_q.payload <= in_data_i.payload_in;
            x_q            <= in_data_i.key ^ (in_data_i.key >> 30);
            phase_q        <= 2'd0;
            round_q        <= 1'b0;
            state_q        <= F_MUL;
          end
        end
        F_MUL: begin
          acc_q <= acc_d;
          if (phase_q == 2'd2) begin
            phase_q <= 2'd0;
            state_q <= round_q ? F_FIN : F_MIX;
          end else begin
            phase_q <= phase_q + 2'd1;
          end
        end
        F_MIX: begin
          x_q     <= acc_q ^ (acc_q >> 27);
          round_q <= 1'b1;
          state_q <= F_MUL;
        end
        F_FIN: begin
          if (IsPow2) begin
            home_q  <= hval[IdxW-1:0];
            state_q <= F_PUSH;
          end else begin
            sh_q    <= hval;
            home_q  <= '0;
            bit_q   <= '0;
            state_q <= F_MOD;
          end
        end
        F_MOD: begin
          bit_q <= bit_q + 2'd1;
          if (bit_q == 2'd0) begin
            acc_q <= 64'(fold);
          end else if (bit_q == 2'd1) begin
            sh_q <= qp >> RecS;
          end else begin
            home_q  <= rem[IdxW-1:0];
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/pshs_queue.sv
// ----------------------------------------------------------------------------
// pshs_queue: two-entry work queue
// Decouples the hash front from the probe back.
// ----------------------------------------------------------------------------
module pshs_queue import pshs_pkg::*; #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
      mem_q[0] <= '0;
      mem_q[1] <= '0;
    end else begin
      if (push_i) begin
        mem_q[wp_q] <= data_i;
        wp_q        <= ~wp_q;
      end
      if (pop_i) rp_q <= ~rp_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/core/pshs_back.sv
// ----------------------------------------------------------------------------
// pshs_back: slot table and linear probe engine
// Clears the key store after reset, probes slots by a read then a check and
// applies insert, remove and lookup; holds the response register.
// ----------------------------------------------------------------------------
module pshs_back import pshs_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024,
  localparam int unsigned IdxW = $clog2(TABLE_SLOTS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] load_limit_i,
  input  logic            q_empty_i,
  output logic            pop_o,
  input  work_t           work_i,
  input  logic [IdxW-1:0] home_i,
  output logic            clearing_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rsp_t            out_data_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_SLOTS - 1);
  localparam logic [IdxW:0]   LastN   = (IdxW+1)'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_RD, B_CHK, B_DONE} bstate_e;

  bstate_e         state_q;
  logic [IdxW-1:0] idx_q, free_idx_q;
  logic [IdxW:0]   n_q;
  logic            free_q;
  logic [CntW-1:0] cnt_q;
  work_t           wk_q;
  rsp_t            res_q, out_q;
  logic            out_valid_q;

  logic [63:0] key_mem [TABLE_SLOTS];
  logic [63:0] pay_mem [TABLE_SLOTS];
  logic [63:0] key_rd_q, pay_rd_q;

  logic            key_we, pay_we;
  logic [IdxW-1:0] key_wa, pay_wa;
  logic [63:0]     key_wd;
  logic            hit, empty, tomb, last, stop, fr_ok, out_ld;
  logic [IdxW-1:0] fr_idx, next_idx;
  status_e         st;
  logic [63:0]     pout;
  logic [CntW-1:0] cnt_d;

  assign hit      = key_rd_q == wk_q.key;
  assign empty    = key_rd_q == KEY_EMPTY;
  assign tomb     = key_rd_q == KEY_TOMB;
  assign last     = n_q == LastN;
  assign stop     = hit || empty || last;
  assign fr_ok    = free_q || empty || tomb;
  assign fr_idx   = free_q ? free_idx_q : idx_q;
  assign next_idx = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;

  always_comb begin
    st     = ST_NOTFOUND;
    pout   = '0;
    cnt_d  = cnt_q;
    key_we = 1'b0;
    key_wa = idx_q;
    key_wd = KEY_EMPTY;
    pay_we = 1'b0;
    pay_wa = idx_q;
    if (hit) begin
      case (wk_q.action)
        ACT_INSERT: begin
          st     = ST_UPDATED;
          pay_we = 1'b1;
        end
        ACT_REMOVE: begin
          st     = ST_REMOVED;
          key_we = 1'b1;
          key_wd = KEY_TOMB;
          cnt_d  = cnt_q - 11'd1;
        end
        default: begin
          st   = ST_FOUND;
          pout = pay_rd_q;
        end
      endcase
    end else if (wk_q.action == ACT_INSERT) begin
      if (cnt_q >= load_limit_i || !fr_ok) begin
        st = ST_FULL;
      end else begin
        st     = ST_INSERTED;
        key_we = 1'b1;
        key_wa = fr_idx;
        key_wd = wk_q.key;
        pay_we = 1'b1;
        pay_wa = fr_idx;
        cnt_d  = cnt_q + 11'd1;
      end
    end
    if (!(state_q == B_CHK && stop)) begin
      key_we = 1'b0;
      pay_we = 1'b0;
    end
    if (state_q == B_CLEAR) begin
      key_we = 1'b1;
      key_wa = idx_q;
      key_wd = KEY_EMPTY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_rd_q <= key_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) pay_mem[pay_wa] <= wk_q.payload;
    pay_rd_q <= pay_mem[idx_q];
  end

  assign pop_o       = (state_q == B_IDLE) && !q_empty_i;
  assign clearing_o  = state_q == B_CLEAR;
  assign out_ld      = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      idx_q       <= '0;
      free_idx_q  <= '0;
      n_q         <= '0;
      free_q      <= 1'b0;
      cnt_q       <= '0;
      wk_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ld) begin
        out_valid_q <= 1'b1;
        out_q       <= res_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_CLEAR: begin
          idx_q <= next_idx;
          if (idx_q == LastIdx) state_q <= B_IDLE;
        end
        B_IDLE: begin
          if (pop_o) begin
            wk_q   <= work_i;
            idx_q  <= home_i;
            n_q    <= '0;
            free_q <= 1'b0;
            if (work_i.bad) begin
              res_q   <= '{status: ST_INVALID, payload_out: 64'd0, live_count: cnt_q};
              state_q <= B_DONE;
            end else begin
              state_q <= B_RD;
            end
          end
        end
        B_RD: state_q <= B_CHK;
        B_CHK: begin
          if (stop) begin
            res_q   <= '{status: st, payload_out: pout, live_count: cnt_d};
            cnt_q   <= cnt_d;
            state_q <= B_DONE;
          end else begin
            if (tomb && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= idx_q;
            end
            idx_q   <= next_idx;
            n_q     <= n_q + 1'b1;
            state_q <= B_RD;
          end
        end
        B_DONE: begin
          if (out_ld) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CHK |-> $past(state_q) == B_RD)
    else $error("probe check without a read");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !pop_o)
    else $error("work taken during clear");

  a_key_wr_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> (state_q == B_CHK || state_q == B_CLEAR))
    else $error("key store written outside probe or clear");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_RD |-> n_q <= LastN)
    else $error("probe ran past one sweep");

endmodule

>>> rtl/core/pointer_hash_set_linear_probe.sv
// ----------------------------------------------------------------------------
// pointer_hash_set_linear_probe: hash set of 64-bit keys with payloads
// Open addressing with linear probing and tombstones over a slot table.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i) carries insert,
//   remove or lookup beats; each gives exactly one response beat on
//   out_valid_o / out_stall_i / out_data_o, in order.
//   cfg_valid_i / cfg_ready_o / cfg_data_i writes load_limit; write it only
//   while no request is in flight.
//   Hashing uses one 32x32 multiplier in six passes; each probed slot is a
//   registered key store read followed by a check, and the result is
//   registered for the response; non-power-of-two table sizes add a modulo.
//   Throughput is set by the shared multiplier in the front, which takes a
//   new request only once the last one is pushed, or by the probe run in
//   the back when runs are long. A two-entry queue separates the two.
//   Reset: live count goes to zero, load_limit to 640, and the key store is
//   cleared slot by slot; requests stall until that ends.
//   A stalled response holds; the back finishes the next request into its
//   result register and waits there.
// ----------------------------------------------------------------------------
module pointer_hash_set_linear_probe import pshs_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  req_t            in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rsp_t            out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CntW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(TABLE_SLOTS);
  localparam int unsigned QW   = $bits(work_t) + IdxW;

  logic [CntW-1:0] load_limit_q;
  logic            clearing, push, full, pop, empty;
  work_t           f_work, b_work;
  logic [IdxW-1:0] f_home, b_home;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_limit_q <= LOAD_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      load_limit_q <= cfg_data_i;
    end
  end

  pshs_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .hold_i(clearing), .push_o(push), .full_i(full),
    .work_o(f_work), .home_o(f_home)
  );

  pshs_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i({f_work, f_home}), .full_o(full),
    .pop_i(pop), .data_o({b_work, b_home}), .empty_o(empty)
  );

  pshs_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk_i, .rst_ni, .load_limit_i(load_limit_q),
    .q_empty_i(empty), .pop_o(pop), .work_i(b_work), .home_i(b_home),
    .clearing_o(clearing), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
